[design/tde_pkg.sv]
// Shared types and constants of the thrust, drag and wrap integrator.
// Used by the controller, the datapath and the top level; no dependencies.
package tde_pkg;

	// Register reset values (Q16.16 unless noted).
	localparam logic [30:0] BODY_MASS_RST  = 31'd65536;
	localparam logic [30:0] DRAG_COEFF_RST = 31'd0;
	localparam logic [30:0] BOUND_X_RST    = 31'd52428800;
	localparam logic [30:0] BOUND_Y_RST    = 31'd29491200;
	localparam logic [16:0] TIME_STEP_RST  = 17'd1092;
	localparam logic        LIMIT_OFF_RST  = 1'b0;
	localparam logic [30:0] STEP_LIMIT_RST = 31'd327680;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_BODY_MASS,
		REG_DRAG_COEFF,
		REG_BOUND_X,
		REG_BOUND_Y,
		REG_TIME_STEP,
		REG_LIMIT_OFF,
		REG_STEP_LIMIT
	} reg_idx_t;

	typedef struct packed {
		logic [30:0] body_mass;
		logic [30:0] drag_coeff;
		logic [30:0] bound_x;
		logic [30:0] bound_y;
		logic [16:0] time_step;
		logic        limit_off;
		logic [30:0] step_limit;
	} cfg_t;

	// Input beat, last field in the lowest bits.
	typedef struct packed {
		logic [15:0] heading_y;
		logic [15:0] heading_x;
		logic [30:0] thrust_mag;
		logic [31:0] ext_force_y;
		logic [31:0] ext_force_x;
	} in_item_t;

	// Result beat, last field in the lowest bits.
	typedef struct packed {
		logic [31:0] acc_y;
		logic [31:0] acc_x;
		logic [31:0] vel_y;
		logic [31:0] vel_x;
		logic [30:0] pos_y;
		logic [30:0] pos_x;
	} out_item_t;

	// Datapath operations issued by the controller.
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_VX2,
		OP_VY2,
		OP_NX2,
		OP_NY2,
		OP_SQRT,
		OP_DRAG,
		OP_DRAGM,
		OP_FD_HI,
		OP_FD_LO,
		OP_FT,
		OP_NET,
		OP_DIV_A,
		OP_ACC,
		OP_ADT,
		OP_NV,
		OP_SDT,
		OP_DIV_T,
		OP_TGT,
		OP_NT_HI,
		OP_NT_LO,
		OP_NUM,
		OP_DIV_N,
		OP_CLAMP,
		OP_NDT,
		OP_POSX,
		OP_DIV_P,
		OP_POS,
		OP_COMMIT
	} op_t;

	typedef enum logic [5:0] {
		ST_IDLE, ST_VX2, ST_VY2, ST_SQ1, ST_SQ1_W, ST_DRAG, ST_DRAGM,
		ST_FD_HI, ST_FD_LO, ST_FT, ST_NET, ST_DIV_A, ST_DIV_A_W, ST_ACC,
		ST_ADT, ST_NV, ST_NX2, ST_NY2, ST_SQ2, ST_SQ2_W, ST_SDT, ST_CMP,
		ST_DIV_T, ST_DIV_T_W, ST_TGT, ST_NT_HI, ST_NT_LO, ST_NUM, ST_DIV_N,
		ST_DIV_N_W, ST_CLAMP, ST_NDT, ST_POSX, ST_DIV_P, ST_DIV_P_W, ST_POS,
		ST_DONE
	} state_t;

	typedef struct packed {
		op_t  op;
		logic axis;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic sqrt_busy;
		logic clamp;
		logic limit_off;
		logic out_free;
	} status_t;

endpackage

[design/tde_div.sv]
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor.
// Standalone; no package needed.
module tde_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic [63:0] quot,
	output logic [31:0] rem
);
	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [63:0] q_q;
	logic [31:0] r_q;
	logic [31:0] d_q;
	logic [32:0] rs;
	logic [32:0] diff;
	logic        ge;

	// One trial subtraction per cycle.
	always_comb begin
		rs   = {r_q, q_q[63]};
		diff = rs - {1'b0, d_q};
		ge   = rs >= {1'b0, d_q};
	end

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (&cnt_q) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Partial remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			q_q <= {q_q[62:0], ge};
			r_q <= ge ? diff[31:0] : rs[31:0];
		end
	end

	assign busy = busy_q;
	assign quot = q_q;
	assign rem  = r_q;
endmodule

[design/tde_sqrt.sv]
// Digit-by-digit integer square root, one root bit per cycle, 64-bit radicand.
// Standalone; no package needed.
module tde_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        busy,
	output logic [31:0] root
);
	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [63:0] rad_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [35:0] rs;
	logic [35:0] trial;
	logic [35:0] diff;
	logic        ge;

	// Bring down two radicand bits and try the next root bit.
	always_comb begin
		rs    = {rem_q, rad_q[63:62]};
		trial = {2'b00, root_q, 2'b01};
		diff  = rs - trial;
		ge    = rs >= trial;
	end

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (&cnt_q) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Remainder, root and radicand shift.
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[61:0], 2'b00};
			rem_q  <= ge ? diff[33:0] : rs[33:0];
			root_q <= {root_q[30:0], ge};
		end
	end

	assign busy = busy_q;
	assign root = root_q;
endmodule

[design/tde_ctrl.sv]
// Sequencer of the integrator: walks the per-item operation list.
// Depends on tde_pkg for the state, command and status types.
module tde_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  tde_pkg::status_t  status,
	output tde_pkg::cmd_t     cmd
);
	import tde_pkg::*;

	state_t st_q, st_d;
	logic   axis_q, axis_d;

	// State and axis registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			axis_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			axis_q <= axis_d;
		end
	end

	// Next state and the operation for this cycle.
	always_comb begin
		st_d     = st_q;
		axis_d   = axis_q;
		cmd.op   = OP_NONE;
		cmd.axis = axis_q;
		case (st_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.op = OP_LOAD;
					axis_d = 1'b0;
					st_d   = ST_VX2;
				end
			end
			ST_VX2: begin cmd.op = OP_VX2; st_d = ST_VY2; end
			ST_VY2: begin cmd.op = OP_VY2; st_d = ST_SQ1; end
			ST_SQ1: begin cmd.op = OP_SQRT; st_d = ST_SQ1_W; end
			ST_SQ1_W: begin
				if (!status.sqrt_busy) st_d = ST_DRAG;
			end
			ST_DRAG: begin cmd.op = OP_DRAG; st_d = ST_DRAGM; end
			ST_DRAGM: begin cmd.op = OP_DRAGM; st_d = ST_FD_HI; end
			ST_FD_HI: begin cmd.op = OP_FD_HI; st_d = ST_FD_LO; end
			ST_FD_LO: begin cmd.op = OP_FD_LO; st_d = ST_FT; end
			ST_FT: begin cmd.op = OP_FT; st_d = ST_NET; end
			ST_NET: begin cmd.op = OP_NET; st_d = ST_DIV_A; end
			ST_DIV_A: begin cmd.op = OP_DIV_A; st_d = ST_DIV_A_W; end
			ST_DIV_A_W: begin
				if (!status.div_busy) st_d = ST_ACC;
			end
			ST_ACC: begin cmd.op = OP_ACC; st_d = ST_ADT; end
			ST_ADT: begin cmd.op = OP_ADT; st_d = ST_NV; end
			ST_NV: begin
				cmd.op = OP_NV;
				if (!axis_q) begin
					axis_d = 1'b1;
					st_d   = ST_FD_HI;
				end else begin
					axis_d = 1'b0;
					st_d   = status.limit_off ? ST_NDT : ST_NX2;
				end
			end
			ST_NX2: begin cmd.op = OP_NX2; st_d = ST_NY2; end
			ST_NY2: begin cmd.op = OP_NY2; st_d = ST_SQ2; end
			ST_SQ2: begin cmd.op = OP_SQRT; st_d = ST_SQ2_W; end
			ST_SQ2_W: begin
				if (!status.sqrt_busy) st_d = ST_SDT;
			end
			ST_SDT: begin cmd.op = OP_SDT; st_d = ST_CMP; end
			// Travel check: clamp only when the new speed would overshoot.
			ST_CMP: begin
				st_d = status.clamp ? ST_DIV_T : ST_NDT;
			end
			ST_DIV_T: begin cmd.op = OP_DIV_T; st_d = ST_DIV_T_W; end
			ST_DIV_T_W: begin
				if (!status.div_busy) st_d = ST_TGT;
			end
			ST_TGT: begin cmd.op = OP_TGT; st_d = ST_NT_HI; end
			ST_NT_HI: begin cmd.op = OP_NT_HI; st_d = ST_NT_LO; end
			ST_NT_LO: begin cmd.op = OP_NT_LO; st_d = ST_NUM; end
			ST_NUM: begin cmd.op = OP_NUM; st_d = ST_DIV_N; end
			ST_DIV_N: begin cmd.op = OP_DIV_N; st_d = ST_DIV_N_W; end
			ST_DIV_N_W: begin
				if (!status.div_busy) st_d = ST_CLAMP;
			end
			ST_CLAMP: begin
				cmd.op = OP_CLAMP;
				if (!axis_q) begin
					axis_d = 1'b1;
					st_d   = ST_NT_HI;
				end else begin
					axis_d = 1'b0;
					st_d   = ST_NDT;
				end
			end
			ST_NDT: begin cmd.op = OP_NDT; st_d = ST_POSX; end
			ST_POSX: begin cmd.op = OP_POSX; st_d = ST_DIV_P; end
			ST_DIV_P: begin cmd.op = OP_DIV_P; st_d = ST_DIV_P_W; end
			ST_DIV_P_W: begin
				if (!status.div_busy) st_d = ST_POS;
			end
			ST_POS: begin
				cmd.op = OP_POS;
				if (!axis_q) begin
					axis_d = 1'b1;
					st_d   = ST_NDT;
				end else begin
					axis_d = 1'b0;
					st_d   = ST_DONE;
				end
			end
			// Hand the result to the output register once it is free.
			ST_DONE: begin
				if (status.out_free) begin
					cmd.op = OP_COMMIT;
					st_d   = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	assign s_tready = (st_q == ST_IDLE);
endmodule

[design/tde_dp.sv]
// Datapath of the integrator: body state, shared multiplier, divider and root unit.
// Depends on tde_pkg, tde_div and tde_sqrt.
module tde_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  tde_pkg::cmd_t      cmd,
	output tde_pkg::status_t   status,
	input  tde_pkg::cfg_t      cfg,
	input  tde_pkg::in_item_t  in_item,
	output tde_pkg::out_item_t out_item,
	output logic               out_valid,
	input  logic               out_ready
);
	import tde_pkg::*;

	localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
	localparam logic [31:0] SAT_MIN = 32'h8000_0000;

	// Body state and working registers.
	in_item_t  in_q;
	out_item_t out_q;
	logic        out_valid_q;
	logic [31:0] vel_x_q, vel_y_q;
	logic [30:0] pos_x_q, pos_y_q;
	logic [63:0] prod_q, t_q;
	logic [46:0] dragm_q, tgt_q;
	logic [62:0] fd_q;
	logic [31:0] net_q, acc_x_q, acc_y_q, nv_x_q, nv_y_q;
	logic [33:0] xm_q;
	logic        xneg_q;

	// Unit interfaces.
	logic        div_start, sqrt_start, div_busy, sqrt_busy;
	logic [63:0] div_dividend, div_quot;
	logic [31:0] div_divisor, div_rem, sqrt_root;
	logic [31:0] mul_a, mul_b;
	logic        mul_en;

	// Per-axis selections and results.
	logic [31:0] v_sel, f_sel, acc_sel, nv_sel;
	logic [15:0] h_sel;
	logic [30:0] pos_sel, bound_sel;
	logic [65:0] ft_w, fd_w, net_w, d_w, nv_w;
	logic [31:0] net_sat, nv_sat, acc_res, clamp_res;
	logic [33:0] x_w;
	logic [30:0] r_w, pos_res;

	function automatic logic [31:0] mag32(input logic [31:0] x);
		return x[31] ? (~x + 32'd1) : x;
	endfunction

	function automatic logic [15:0] mag16(input logic [15:0] x);
		return x[15] ? (~x + 16'd1) : x;
	endfunction

	function automatic logic [31:0] sat32(input logic [65:0] x);
		logic [31:0] r;
		if (!x[65] && (|x[64:31])) r = SAT_MAX;
		else if (x[65] && !(&x[64:31])) r = SAT_MIN;
		else r = x[31:0];
		return r;
	endfunction

	// Axis selection.
	always_comb begin
		v_sel     = cmd.axis ? vel_y_q : vel_x_q;
		f_sel     = cmd.axis ? in_q.ext_force_y : in_q.ext_force_x;
		h_sel     = cmd.axis ? in_q.heading_y : in_q.heading_x;
		acc_sel   = cmd.axis ? acc_y_q : acc_x_q;
		nv_sel    = cmd.axis ? nv_y_q : nv_x_q;
		pos_sel   = cmd.axis ? pos_y_q : pos_x_q;
		bound_sel = cmd.axis ? cfg.bound_y : cfg.bound_x;
	end

	// Shared multiplier operands.
	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		case (cmd.op)
			OP_VX2: begin mul_a = mag32(vel_x_q); mul_b = mag32(vel_x_q); end
			OP_VY2: begin mul_a = mag32(vel_y_q); mul_b = mag32(vel_y_q); end
			OP_NX2: begin mul_a = mag32(nv_x_q); mul_b = mag32(nv_x_q); end
			OP_NY2: begin mul_a = mag32(nv_y_q); mul_b = mag32(nv_y_q); end
			OP_DRAG: begin mul_a = {1'b0, cfg.drag_coeff}; mul_b = sqrt_root; end
			OP_FD_HI: begin mul_a = mag32(v_sel); mul_b = {1'b0, dragm_q[46:16]}; end
			OP_FD_LO: begin mul_a = mag32(v_sel); mul_b = {16'd0, dragm_q[15:0]}; end
			OP_FT: begin mul_a = {16'd0, mag16(h_sel)}; mul_b = {1'b0, in_q.thrust_mag}; end
			OP_ADT: begin mul_a = mag32(acc_sel); mul_b = {15'd0, cfg.time_step}; end
			OP_SDT: begin mul_a = sqrt_root; mul_b = {15'd0, cfg.time_step}; end
			OP_NT_HI: begin mul_a = mag32(nv_sel); mul_b = {1'b0, tgt_q[46:16]}; end
			OP_NT_LO: begin mul_a = mag32(nv_sel); mul_b = {16'd0, tgt_q[15:0]}; end
			OP_NDT: begin mul_a = mag32(nv_sel); mul_b = {15'd0, cfg.time_step}; end
			default: begin mul_en = 1'b0; end
		endcase
	end

	// Net force, acceleration, velocity and wrap arithmetic.
	always_comb begin
		ft_w = {34'd0, prod_q[45:14]};
		if (h_sel[15]) ft_w = ~ft_w + 66'd1;
		fd_w = {3'd0, fd_q};
		if (v_sel[31]) fd_w = ~fd_w + 66'd1;
		net_w   = {{34{f_sel[31]}}, f_sel} + ft_w - fd_w;
		net_sat = sat32(net_w);

		d_w = {34'd0, prod_q[47:16]};
		if (acc_sel[31]) d_w = ~d_w + 66'd1;
		nv_w   = {{34{v_sel[31]}}, v_sel} + d_w;
		nv_sat = sat32(nv_w);

		// Quotient of |net|/mass with the net force's sign, saturated; zero for zero mass.
		if (cfg.body_mass == '0) begin
			acc_res = '0;
		end else if (!net_q[31]) begin
			acc_res = (|div_quot[63:31]) ? SAT_MAX : div_quot[31:0];
		end else if ((|div_quot[63:32]) || (div_quot[31] && (|div_quot[30:0]))) begin
			acc_res = SAT_MIN;
		end else begin
			acc_res = ~div_quot[31:0] + 32'd1;
		end

		clamp_res = nv_sel[31] ? (~div_quot[31:0] + 32'd1) : div_quot[31:0];

		// Position plus signed step, before the floor modulo.
		if (nv_sel[31]) x_w = {3'd0, pos_sel} - {2'd0, prod_q[47:16]};
		else x_w = {3'd0, pos_sel} + {2'd0, prod_q[47:16]};

		r_w = div_rem[30:0];
		if (bound_sel == '0) pos_res = '0;
		else if (xneg_q && (r_w != '0)) pos_res = bound_sel - r_w;
		else pos_res = r_w;
	end

	// Divider and root unit launches.
	always_comb begin
		div_start    = 1'b1;
		div_dividend = '0;
		div_divisor  = '0;
		case (cmd.op)
			OP_DIV_A: begin
				div_dividend = {16'd0, mag32(net_q), 16'd0};
				div_divisor  = {1'b0, cfg.body_mass};
			end
			OP_DIV_T: begin
				div_dividend = {17'd0, cfg.step_limit, 16'd0};
				div_divisor  = {15'd0, cfg.time_step};
			end
			OP_DIV_N: begin
				div_dividend = t_q;
				div_divisor  = sqrt_root;
			end
			OP_DIV_P: begin
				div_dividend = {30'd0, xm_q};
				div_divisor  = {1'b0, bound_sel};
			end
			default: begin div_start = 1'b0; end
		endcase
		sqrt_start = (cmd.op == OP_SQRT);
	end

	tde_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	tde_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (t_q + prod_q),
		.busy     (sqrt_busy),
		.root     (sqrt_root)
	);

	// Body state and output handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel_x_q     <= '0;
			vel_y_q     <= '0;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_POS) begin
				if (cmd.axis) pos_y_q <= pos_res;
				else pos_x_q <= pos_res;
			end
			if (cmd.op == OP_COMMIT) begin
				vel_x_q     <= nv_x_q;
				vel_y_q     <= nv_y_q;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of one item.
	always_ff @(posedge clk) begin
		if (mul_en) prod_q <= mul_a * mul_b;
		case (cmd.op)
			OP_LOAD: in_q <= in_item;
			OP_VY2, OP_NY2, OP_FD_LO, OP_NT_LO: t_q <= prod_q;
			OP_DRAGM: dragm_q <= prod_q[62:16];
			OP_FT: fd_q <= t_q[62:0] + {31'd0, prod_q[47:16]};
			OP_NET: net_q <= net_sat;
			OP_ACC: begin
				if (cmd.axis) acc_y_q <= acc_res;
				else acc_x_q <= acc_res;
			end
			OP_NV: begin
				if (cmd.axis) nv_y_q <= nv_sat;
				else nv_x_q <= nv_sat;
			end
			OP_TGT: tgt_q <= div_quot[46:0];
			OP_NUM: t_q <= {t_q[47:0], 16'd0} + prod_q;
			OP_CLAMP: begin
				if (cmd.axis) nv_y_q <= clamp_res;
				else nv_x_q <= clamp_res;
			end
			OP_POSX: begin
				xneg_q <= x_w[33];
				xm_q   <= x_w[33] ? (~x_w + 34'd1) : x_w;
			end
			OP_COMMIT: begin
				out_q.pos_x <= pos_x_q;
				out_q.pos_y <= pos_y_q;
				out_q.vel_x <= nv_x_q;
				out_q.vel_y <= nv_y_q;
				out_q.acc_x <= acc_x_q;
				out_q.acc_y <= acc_y_q;
			end
			default: begin
			end
		endcase
	end

	// Status back to the controller.
	always_comb begin
		status.div_busy  = div_busy;
		status.sqrt_busy = sqrt_busy;
		status.clamp     = prod_q[48:0] > {2'b00, cfg.step_limit, 16'd0};
		status.limit_off = cfg.limit_off;
		status.out_free  = !out_valid_q || out_ready;
	end

	assign out_item  = out_q;
	assign out_valid = out_valid_q;
endmodule

[design/thrust_drag_euler_wrap_step_top.sv]
// How long an item takes depends on whether the travel limit is off, on and not
// clamping, or clamping the velocity; the 64-step shared divider (up to seven
// divisions) and the 32-step root unit set it. Items go one at a time: the next
// input beat can be accepted in the cycle after the result is committed. A
// finished result waits in the output register while the next item is accepted.
// Reset (arst_n low) clears velocity and position to zero and loads the register
// defaults; no clearing pass is needed.
// Top level: configuration registers, controller and datapath.
// Depends on tde_pkg, tde_ctrl and tde_dp.
module thrust_drag_euler_wrap_step_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// ext_force_x, ext_force_y, thrust_mag, heading_x, heading_y, zero pad
	input  logic [127:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// pos_x, pos_y, vel_x, vel_y, acc_x, acc_y, zero pad
	output logic [191:0] m_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_addr,
	input  logic [30:0]  cfg_wdata
);
	import tde_pkg::*;

	cfg_t      cfg_q;
	cmd_t      cmd;
	status_t   status;
	in_item_t  in_item;
	out_item_t out_item;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.body_mass  <= BODY_MASS_RST;
			cfg_q.drag_coeff <= DRAG_COEFF_RST;
			cfg_q.bound_x    <= BOUND_X_RST;
			cfg_q.bound_y    <= BOUND_Y_RST;
			cfg_q.time_step  <= TIME_STEP_RST;
			cfg_q.limit_off  <= LIMIT_OFF_RST;
			cfg_q.step_limit <= STEP_LIMIT_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_addr))
				REG_BODY_MASS:  cfg_q.body_mass  <= cfg_wdata;
				REG_DRAG_COEFF: cfg_q.drag_coeff <= cfg_wdata;
				REG_BOUND_X:    cfg_q.bound_x    <= cfg_wdata;
				REG_BOUND_Y:    cfg_q.bound_y    <= cfg_wdata;
				REG_TIME_STEP:  cfg_q.time_step  <= cfg_wdata[16:0];
				REG_LIMIT_OFF:  cfg_q.limit_off  <= cfg_wdata[0];
				REG_STEP_LIMIT: cfg_q.step_limit <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign in_item = in_item_t'(s_tdata[126:0]);
	assign m_tdata = {2'b00, out_item};

	tde_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	tde_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg       (cfg_q),
		.in_item   (in_item),
		.out_item  (out_item),
		.out_valid (m_tvalid),
		.out_ready (m_tready)
	);

	// An accepted beat starts work: the input side closes on the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input still open after accepting a beat");

	// The divider and the root unit never run at the same time.
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(status.div_busy && status.sqrt_busy))
		else $error("divider and root unit busy together");

	// While idle no arithmetic unit is still running.
	a_idle_units_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!status.div_busy && !status.sqrt_busy))
		else $error("unit busy while idle");

	// A new result appears only when the controller commits it.
	a_result_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid ##1 m_tvalid) |-> $past(cmd.op == OP_COMMIT))
		else $error("result without commit");
endmodule

[test/tb_top.sv]
// Testbench for the thrust, drag and wrap Euler integrator: random and
// directed frames checked beat by beat against a built-in fixed-point predictor.
// Depends on tde_pkg and thrust_drag_euler_wrap_step_top.
`timescale 1ns / 100ps

module tb_top;
	import tde_pkg::*;

	localparam int WATCHDOG_LIMIT = 40000;
	localparam int DRAIN_CYCLES   = 700;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [191:0] m_tdata;
	logic         cfg_we;
	logic [2:0]   cfg_addr;
	logic [30:0]  cfg_wdata;

	thrust_drag_euler_wrap_step_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	// Predictor copy of the registers and the body state.
	longint unsigned mass_r, drag_r, bnd_x_r, bnd_y_r, dt_r, lim_off_r, lim_r;
	logic [31:0]     body_vx, body_vy, body_px, body_py;

	in_item_t  frame_q[$];
	out_item_t motion_q[$];
	in_item_t  cur_frame;
	int        send_idle, recv_idle;
	int        n_bad, n_out, hold_left, idle_cycles;
	bit        frame_taken, hold_done;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned mag(longint x);
		return (x < 0) ? longint'(0) - x : x;
	endfunction

	function automatic longint signed_of(longint unsigned m, bit neg);
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint clamp32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	// Bitwise integer square root, rounded down.
	function automatic longint unsigned root64(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [31:0] wrap_coord(logic [31:0] p, longint d, longint unsigned bnd);
		longint x, r;
		if (bnd == 0) return 32'd0;
		x = longint'($signed(p)) + d;
		r = x % longint'(bnd);
		if (r < 0) r = r + longint'(bnd);
		return r[31:0];
	endfunction

	// One frame of motion: forces, acceleration, velocity, travel limit, wrap.
	function automatic out_item_t integrate_frame(in_item_t it);
		longint          v[2], f[2], h[2], a[2], nv[2], net, ft, fd;
		longint unsigned speed, dragm, s, tgt, thrust;
		logic [127:0]    prod;
		out_item_t       o;
		v[0] = longint'($signed(body_vx));
		v[1] = longint'($signed(body_vy));
		f[0] = longint'($signed(it.ext_force_x));
		f[1] = longint'($signed(it.ext_force_y));
		h[0] = longint'($signed(it.heading_x));
		h[1] = longint'($signed(it.heading_y));
		thrust = it.thrust_mag;
		speed = root64(mag(v[0]) * mag(v[0]) + mag(v[1]) * mag(v[1]));
		dragm = (drag_r * speed) >> 16;
		for (int i = 0; i < 2; i++) begin
			ft = signed_of((mag(h[i]) * thrust) >> 14, h[i] < 0);
			prod = 128'(mag(v[i])) * 128'(dragm);
			fd = signed_of(prod[79:16], v[i] < 0);
			net = clamp32(f[i] + ft - fd);
			if (mass_r == 0)
				a[i] = 0;
			else
				a[i] = clamp32(signed_of((mag(net) << 16) / mass_r, net < 0));
			nv[i] = clamp32(v[i] + signed_of((mag(a[i]) * dt_r) >> 16, a[i] < 0));
		end
		if (lim_off_r == 0) begin
			s = root64(mag(nv[0]) * mag(nv[0]) + mag(nv[1]) * mag(nv[1]));
			if (s * dt_r > (lim_r << 16)) begin
				tgt = (lim_r << 16) / dt_r;
				for (int i = 0; i < 2; i++)
					nv[i] = signed_of((mag(nv[i]) * tgt) / s, nv[i] < 0);
			end
		end
		body_vx = nv[0][31:0];
		body_vy = nv[1][31:0];
		body_px = wrap_coord(body_px,
			signed_of((mag(nv[0]) * dt_r) >> 16, nv[0] < 0), bnd_x_r);
		body_py = wrap_coord(body_py,
			signed_of((mag(nv[1]) * dt_r) >> 16, nv[1] < 0), bnd_y_r);
		o.pos_x = body_px[30:0];
		o.pos_y = body_py[30:0];
		o.vel_x = body_vx;
		o.vel_y = body_vy;
		o.acc_x = a[0][31:0];
		o.acc_y = a[1][31:0];
		return o;
	endfunction

	// Input beat sampling and prediction.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			motion_q.push_back(integrate_frame(cur_frame));
			frame_taken = 1'b1;
		end
	end

	// Driver: offers the next frame or idles at random.
	always @(negedge clk) begin
		if (arst_n && (frame_taken || !s_tvalid)) begin
			frame_taken = 1'b0;
			if (frame_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
				cur_frame = frame_q.pop_front();
				s_tdata  <= {1'b0, cur_frame};
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls plus one long hold-off to fill the block.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && n_out == 150) begin
				hold_done = 1'b1;
				hold_left = 3000;
			end
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_idle);
			end
		end
	end

	// Monitor: compares each result beat with the oldest prediction.
	always @(posedge clk) begin
		out_item_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[189:0];
			n_out = n_out + 1;
			if (motion_q.size() == 0) begin
				n_bad = n_bad + 1;
				if (n_bad <= 10) $display("unexpected result beat %h", got);
			end else begin
				want = motion_q.pop_front();
				if (got != want) begin
					n_bad = n_bad + 1;
					if (n_bad <= 10) begin
						$display("mismatch: got pos %h/%h vel %h/%h acc %h/%h",
							got.pos_x, got.pos_y, got.vel_x, got.vel_y,
							got.acc_x, got.acc_y);
						$display("  expected pos %h/%h vel %h/%h acc %h/%h",
							want.pos_x, want.pos_y, want.vel_x, want.vel_y,
							want.acc_x, want.acc_y);
					end
				end
			end
		end
	end

	// Watchdog on cycles with no beat on either side and no register write.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles = idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [30:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_BODY_MASS:  mass_r = val;
			REG_DRAG_COEFF: drag_r = val;
			REG_BOUND_X:    bnd_x_r = val;
			REG_BOUND_Y:    bnd_y_r = val;
			REG_TIME_STEP:  dt_r = val[16:0];
			REG_LIMIT_OFF:  lim_off_r = val[0];
			REG_STEP_LIMIT: lim_r = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(logic [30:0] m, logic [30:0] d, logic [30:0] bx,
			logic [30:0] by, logic [16:0] t, logic lo, logic [30:0] sl);
		write_reg(REG_BODY_MASS, m);
		write_reg(REG_DRAG_COEFF, d);
		write_reg(REG_BOUND_X, bx);
		write_reg(REG_BOUND_Y, by);
		write_reg(REG_TIME_STEP, {14'd0, t});
		write_reg(REG_LIMIT_OFF, {30'd0, lo});
		write_reg(REG_STEP_LIMIT, sl);
	endtask

	function automatic in_item_t make_frame(logic [31:0] fx, logic [31:0] fy,
			logic [30:0] th, int hx, int hy);
		in_item_t it;
		it.ext_force_x = fx;
		it.ext_force_y = fy;
		it.thrust_mag  = th;
		it.heading_x   = hx[15:0];
		it.heading_y   = hy[15:0];
		return it;
	endfunction

	// Mostly plausible flight frames, some with full-range fields.
	function automatic in_item_t random_frame();
		int hx, hy;
		hx = $urandom_range(0, 32768) - 16384;
		hy = $urandom_range(0, 32768) - 16384;
		if ($urandom_range(0, 99) < 70)
			return make_frame($urandom_range(0, 2097152) - 1048576,
				$urandom_range(0, 2097152) - 1048576,
				31'($urandom_range(0, 4194304)), hx, hy);
		return make_frame($urandom, $urandom, 31'($urandom), hx, hy);
	endfunction

	task automatic wait_drained();
		wait (frame_q.size() == 0 && !s_tvalid && motion_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		m_tready  = 1'b0;
		cfg_we    = 1'b0;
		cfg_addr  = '0;
		cfg_wdata = '0;
		n_bad = 0;
		n_out = 0;
		hold_left = 0;
		idle_cycles = 0;
		frame_taken = 1'b0;
		hold_done = 1'b0;
		send_idle = 36;
		recv_idle = 71;
		mass_r = BODY_MASS_RST;
		drag_r = DRAG_COEFF_RST;
		bnd_x_r = BOUND_X_RST;
		bnd_y_r = BOUND_Y_RST;
		dt_r = TIME_STEP_RST;
		lim_off_r = LIMIT_OFF_RST;
		lim_r = STEP_LIMIT_RST;
		body_vx = '0;
		body_vy = '0;
		body_px = '0;
		body_py = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed frames under reset registers: zero, extremes, each heading sign.
		frame_q.push_back(make_frame(0, 0, 0, 0, 0));
		frame_q.push_back(make_frame(0, 0, 31'h7fffffff, 16384, 0));
		frame_q.push_back(make_frame(0, 0, 31'h7fffffff, -16384, 0));
		frame_q.push_back(make_frame(0, 0, 31'h7fffffff, 0, 16384));
		frame_q.push_back(make_frame(0, 0, 31'h7fffffff, 0, -16384));
		frame_q.push_back(make_frame(32'h7fffffff, 32'h80000000, 0, 0, 0));
		frame_q.push_back(make_frame(32'h80000000, 32'h7fffffff, 31'h7fffffff, 11585, -11585));
		frame_q.push_back(make_frame(32'hffffffff, 32'h00000001, 1, -1, 1));
		frame_q.push_back(make_frame(32'h80000000, 32'h80000000, 31'h7fffffff, -16384, -16384));
		frame_q.push_back(make_frame(32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 16384, 16384));
		for (int i = 0; i < 60; i++) frame_q.push_back(random_frame());
		wait_drained();

		// Drag on, small wrap area, big time step, tight travel limit.
		write_all(31'd131072, 31'd6554, 31'd655360, 31'd327680, 17'd65536, 1'b0, 31'd196608);
		for (int i = 0; i < 8; i++)
			frame_q.push_back(make_frame(0, 0, 31'd655360, 16384, -16384));
		for (int i = 0; i < 60; i++) frame_q.push_back(random_frame());
		wait_drained();

		// Zero mass, heaviest drag, largest bounds, tiny step, limit off.
		send_idle = 71;
		recv_idle = 36;
		write_all(31'd0, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 17'd1, 1'b1, 31'h7fffffff);
		for (int i = 0; i < 60; i++) frame_q.push_back(random_frame());
		wait_drained();

		// Lightest mass, zero time step, zero and minimal bounds, zero limit.
		write_all(31'd1, 31'd0, 31'd65536, 31'd0, 17'd0, 1'b0, 31'd0);
		for (int i = 0; i < 50; i++) frame_q.push_back(random_frame());
		wait_drained();

		// Heaviest mass, unit step, zero limit clamps every velocity to rest.
		send_idle = 0;
		recv_idle = 0;
		write_all(31'h7fffffff, 31'd65, 31'd52428800, 31'd65536, 17'd65536, 1'b0, 31'd0);
		for (int i = 0; i < 40; i++) frame_q.push_back(random_frame());
		wait_drained();

		// Moderate flight settings with a limit that sometimes clamps.
		write_all(31'd65536, 31'd655, 31'd52428800, 31'd29491200, 17'd1092, 1'b0, 31'd327680);
		for (int i = 0; i < 120; i++) frame_q.push_back(random_frame());
		wait_drained();

		if (n_bad == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
